// ----- sv/lbf_pkg.sv -----
// shared constants and types for the lorentz boost pipeline
package lbf_pkg;

    localparam int BETA_W      = 31;
    localparam int B2_W        = 62;
    localparam int D_W         = 61;
    localparam int Q_W         = 125;
    localparam int G_W         = 63;
    localparam int K_W         = 62;
    localparam int SQ_RW       = 65;
    localparam int DEN_W       = 63;

    localparam int DIV1_STAGES = Q_W;
    localparam int SQRT_STAGES = G_W;
    localparam int KDIV_STAGES = K_W;
    localparam int MUL_LAT     = 2;
    localparam int GAMMA_LAT   = DIV1_STAGES + SQRT_STAGES + MUL_LAT + KDIV_STAGES;
    localparam int PIPE_LAT    = GAMMA_LAT + 9;

    localparam logic [B2_W-1:0]  B2_ONE   = 62'd1 << 60;
    localparam logic [D_W-1:0]   D_ONE    = 61'd1 << 60;
    localparam logic [63:0]      G_ONE    = 64'd1 << 32;
    localparam logic signed [31:0] HALF_30 = 32'sd1 <<< 29;
    localparam logic signed [32:0] HALF_32 = 33'sd1 <<< 31;

    typedef logic [G_W-1:0] t_gamma;
    typedef logic [K_W-1:0] t_coef;

endpackage

// ----- sv/lorentz_boost_four_vector_top.sv -----
// General Lorentz boost of a fixed-point four-momentum. One transfer is taken every
// cycle unless stalled; the depth is set by the gamma unit, a bit-per-stage
// 2^124/(1-beta^2) divider, a two-bit-per-stage square root and a bit-per-stage
// gamma^2/(gamma+1) divider, plus nine stages of multipliers and registers. A stall
// on the output while a result is held freezes the whole pipeline and is passed
// straight back to the input. A velocity of light speed or more passes the momentum
// through with beta_invalid set; out-of-range results saturate and set overflow.
module lorentz_boost_four_vector_top
    import lbf_pkg::*;
#(
    parameter int MOMENTUM_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [MOMENTUM_WIDTH-1:0]  i_energy_in,
    input  logic signed [MOMENTUM_WIDTH-1:0]  i_mom_x_in,
    input  logic signed [MOMENTUM_WIDTH-1:0]  i_mom_y_in,
    input  logic signed [MOMENTUM_WIDTH-1:0]  i_mom_z_in,
    input  logic signed [BETA_W-1:0]          i_beta_x,
    input  logic signed [BETA_W-1:0]          i_beta_y,
    input  logic signed [BETA_W-1:0]          i_beta_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [MOMENTUM_WIDTH-1:0]  o_energy_out,
    output logic signed [MOMENTUM_WIDTH-1:0]  o_mom_x_out,
    output logic signed [MOMENTUM_WIDTH-1:0]  o_mom_y_out,
    output logic signed [MOMENTUM_WIDTH-1:0]  o_mom_z_out,
    output logic                              o_beta_invalid,
    output logic                              o_overflow
);
    localparam int W = MOMENTUM_WIDTH;
    localparam logic signed [W+37:0] SAT_MAX = (W+38)'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [W+37:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic [3:0][W-1:0]      p;
        logic [2:0][BETA_W-1:0] b;
    } t_item;

    typedef struct packed {
        t_item item;
        logic  inv;
    } t_core;

    typedef struct packed {
        t_core      core;
        logic [W+2:0] bp;
        logic [W+2:0] ebp;
    } t_mid;

    typedef struct packed {
        logic [3:0][W-1:0] p;
        logic [W+34:0]     e;
        logic              inv;
    } t_tail;

    logic                w_en;
    logic [PIPE_LAT-1:0] r_vld;

    assign w_en    = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // ---- front: beta squared and beta . p
    t_item                w_in;
    t_item                w_in2;
    logic signed [61:0]   w_sq [3];
    logic signed [W+30:0] w_pb [3];

    assign w_in.p = {i_mom_z_in, i_mom_y_in, i_mom_x_in, i_energy_in};
    assign w_in.b = {i_beta_z, i_beta_y, i_beta_x};

    for (genvar i = 0; i < 3; i++) begin : g_front
        lbf_mul #(.AW(BETA_W), .BW(BETA_W)) u_sq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   ($signed(w_in.b[i])),
            .i_b   ($signed(w_in.b[i])),
            .o_p   (w_sq[i])
        );
        lbf_mul #(.AW(W), .BW(BETA_W)) u_pb (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   ($signed(w_in.p[i+1])),
            .i_b   ($signed(w_in.b[i])),
            .o_p   (w_pb[i])
        );
    end

    lbf_dly #(.WIDTH($bits(t_item)), .DEPTH(MUL_LAT)) u_dly_in (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_in),
        .o_q   (w_in2)
    );

    logic [B2_W-1:0]      w_b2;
    logic                 w_inv;
    logic [D_W-1:0]       w_d;
    logic signed [W+32:0] w_acc;
    logic signed [W+2:0]  w_bp;
    logic signed [W+2:0]  w_ebp;
    t_mid                 r_a_mid;
    logic [D_W-1:0]       r_a_d;

    always_comb begin
        w_b2  = $unsigned(w_sq[0]) + $unsigned(w_sq[1]) + $unsigned(w_sq[2]);
        w_inv = w_b2 >= B2_ONE;
        w_d   = w_inv ? D_ONE : D_W'(B2_ONE - w_b2);
        w_acc = (W+33)'(w_pb[0]) + (W+33)'(w_pb[1]) + (W+33)'(w_pb[2]);
        w_bp  = (W+3)'((w_acc + (W+33)'(HALF_30)) >>> 30);
        w_ebp = (W+3)'($signed(w_in2.p[0])) + w_bp;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_mid.core.item <= w_in2;
            r_a_mid.core.inv  <= w_inv;
            r_a_mid.bp        <= w_bp;
            r_a_mid.ebp       <= w_ebp;
            r_a_d             <= w_d;
        end
    end

    // ---- gamma and the aligned payload
    t_gamma w_g;
    t_coef  w_k;
    t_mid   w_g_mid;

    lbf_gamma u_gamma (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_a_d),
        .o_g   (w_g),
        .o_k   (w_k)
    );

    lbf_dly #(.WIDTH($bits(t_mid)), .DEPTH(GAMMA_LAT)) u_dly_mid (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_a_mid),
        .o_q   (w_g_mid)
    );

    // ---- back: E' and the common term t
    logic signed [W+66:0] w_m1;
    logic signed [W+66:0] w_m2;
    logic signed [W+63:0] w_m3;
    t_core                w_g2_core;

    lbf_mul #(.AW(64), .BW(W+3)) u_m1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ($signed({1'b0, w_g})),
        .i_b   ($signed(w_g_mid.ebp)),
        .o_p   (w_m1)
    );

    lbf_mul #(.AW(64), .BW(W+3)) u_m2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ($signed({2'b00, w_k})),
        .i_b   ($signed(w_g_mid.bp)),
        .o_p   (w_m2)
    );

    lbf_mul #(.AW(64), .BW(W)) u_m3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ($signed({1'b0, w_g})),
        .i_b   ($signed(w_g_mid.core.item.p[0])),
        .o_p   (w_m3)
    );

    lbf_dly #(.WIDTH($bits(t_core)), .DEPTH(MUL_LAT)) u_dly_core (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_g_mid.core),
        .o_q   (w_g2_core)
    );

    logic signed [W+67:0] w_tsum;
    logic signed [W+34:0] w_e_full;
    logic signed [W+35:0] w_t;
    logic signed [W+34:0] r_h_e;
    logic signed [W+35:0] r_h_t;
    t_core                r_h_core;

    always_comb begin
        w_e_full = (W+35)'((w_m1 + (W+67)'(HALF_32)) >>> 32);
        w_tsum   = (W+68)'(w_m2) + (W+68)'(w_m3) + (W+68)'(HALF_32);
        w_t      = (W+36)'(w_tsum >>> 32);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_e    <= w_e_full;
            r_h_t    <= w_t;
            r_h_core <= w_g2_core;
        end
    end

    // ---- momentum update p + t*beta
    logic signed [W+66:0] w_tb [3];
    t_tail                w_h_tail;
    t_tail                w_i_tail;

    for (genvar i = 0; i < 3; i++) begin : g_back
        lbf_mul #(.AW(W+36), .BW(BETA_W)) u_tb (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_h_t),
            .i_b   ($signed(r_h_core.item.b[i])),
            .o_p   (w_tb[i])
        );
    end

    assign w_h_tail.p   = r_h_core.item.p;
    assign w_h_tail.e   = r_h_e;
    assign w_h_tail.inv = r_h_core.inv;

    lbf_dly #(.WIDTH($bits(t_tail)), .DEPTH(MUL_LAT)) u_dly_tail (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_h_tail),
        .o_q   (w_i_tail)
    );

    // ---- saturation and output register
    logic signed [W+37:0] w_v [4];
    logic [3:0][W-1:0]    n_o_p;
    logic                 n_o_ovf;
    logic [3:0][W-1:0]    r_o_p;
    logic                 r_o_inv;
    logic                 r_o_ovf;

    always_comb begin
        w_v[0] = (W+38)'($signed(w_i_tail.e));
        for (int i = 1; i < 4; i++) begin
            w_v[i] = (W+38)'($signed(w_i_tail.p[i]))
                   + (W+38)'((w_tb[i-1] + (W+67)'(HALF_30)) >>> 30);
        end
        n_o_ovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (w_v[i] > SAT_MAX) begin
                n_o_p[i] = SAT_MAX[W-1:0];
                n_o_ovf  = 1'b1;
            end else if (w_v[i] < SAT_MIN) begin
                n_o_p[i] = SAT_MIN[W-1:0];
                n_o_ovf  = 1'b1;
            end else begin
                n_o_p[i] = w_v[i][W-1:0];
            end
        end
        // velocity at or above light speed: pass the momentum through
        if (w_i_tail.inv) begin
            n_o_p   = w_i_tail.p;
            n_o_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_p   <= n_o_p;
            r_o_inv <= w_i_tail.inv;
            r_o_ovf <= n_o_ovf;
        end
    end

    assign o_energy_out   = r_o_p[0];
    assign o_mom_x_out    = r_o_p[1];
    assign o_mom_y_out    = r_o_p[2];
    assign o_mom_z_out    = r_o_p[3];
    assign o_beta_invalid = r_o_inv;
    assign o_overflow     = r_o_ovf;

endmodule

// ----- sv/lbf_mul.sv -----
// signed multiplier built from 33x33 partial products, two register stages
module lbf_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int AX = NA * 32;
    localparam int BX = NB * 32;
    localparam int PW = AW + BW;

    logic signed [AX-1:0]  w_ax;
    logic signed [BX-1:0]  w_bx;
    logic signed [32:0]    w_ca [NA];
    logic signed [32:0]    w_cb [NB];
    logic signed [65:0]    r_pp [NA][NB];
    logic signed [PW-1:0]  n_p;
    logic signed [PW-1:0]  r_p;

    assign w_ax = AX'(i_a);
    assign w_bx = BX'(i_b);

    // low chunks are unsigned, the top chunk carries the sign
    always_comb begin
        for (int ia = 0; ia < NA; ia++) begin
            w_ca[ia] = {1'b0, w_ax[32*ia +: 32]};
        end
        w_ca[NA-1] = {w_ax[AX-1], w_ax[AX-1 -: 32]};
        for (int ib = 0; ib < NB; ib++) begin
            w_cb[ib] = {1'b0, w_bx[32*ib +: 32]};
        end
        w_cb[NB-1] = {w_bx[BX-1], w_bx[BX-1 -: 32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ia = 0; ia < NA; ia++) begin
                for (int ib = 0; ib < NB; ib++) begin
                    r_pp[ia][ib] <= w_ca[ia] * w_cb[ib];
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int ia = 0; ia < NA; ia++) begin
            for (int ib = 0; ib < NB; ib++) begin
                n_p = n_p + (PW'(r_pp[ia][ib]) <<< (32 * (ia + ib)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- sv/lbf_dly.sv -----
// fixed delay line with a shared advance enable
module lbf_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WIDTH-1:0]  i_d,
    output logic [WIDTH-1:0]  o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// ----- sv/lbf_gamma.sv -----
// gamma and (gamma-1)/beta^2 from 1 - beta^2: divider, square root, square, divider
module lbf_gamma
    import lbf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [D_W-1:0]  i_d,
    output t_gamma          o_g,
    output t_coef           o_k
);
    // 2^124 / d, one quotient bit per stage
    logic [D_W-1:0]   r_dv_d   [DIV1_STAGES];
    logic [D_W-1:0]   r_dv_rem [DIV1_STAGES];
    logic [Q_W-1:0]   r_dv_q   [DIV1_STAGES];

    for (genvar s = 0; s < DIV1_STAGES; s++) begin : g_div
        logic [D_W-1:0] w_d;
        logic [D_W-1:0] w_rem;
        logic [Q_W-1:0] w_q;
        logic [D_W:0]   w_sh;
        logic           w_ge;
        if (s == 0) begin : g_first
            assign w_d   = i_d;
            assign w_rem = '0;
            assign w_q   = '0;
        end else begin : g_next
            assign w_d   = r_dv_d[s-1];
            assign w_rem = r_dv_rem[s-1];
            assign w_q   = r_dv_q[s-1];
        end
        // the numerator has a single one at its top bit
        assign w_sh = {w_rem, (s == 0)};
        assign w_ge = w_sh >= {1'b0, w_d};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_d[s]   <= w_d;
                r_dv_rem[s] <= w_ge ? D_W'(w_sh - {1'b0, w_d}) : w_sh[D_W-1:0];
                r_dv_q[s]   <= {w_q[Q_W-2:0], w_ge};
            end
        end
    end

    // integer square root, two radicand bits per stage
    logic [Q_W:0]     r_sq_q    [SQRT_STAGES];
    logic [SQ_RW-1:0] r_sq_rem  [SQRT_STAGES];
    logic [G_W-1:0]   r_sq_root [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
        logic [Q_W:0]     w_q;
        logic [SQ_RW-1:0] w_rem;
        logic [G_W-1:0]   w_root;
        logic [SQ_RW+1:0] w_sh;
        logic [SQ_RW+1:0] w_trial;
        logic             w_ge;
        if (s == 0) begin : g_first
            assign w_q    = {1'b0, r_dv_q[DIV1_STAGES-1]};
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_q    = r_sq_q[s-1];
            assign w_rem  = r_sq_rem[s-1];
            assign w_root = r_sq_root[s-1];
        end
        assign w_sh    = {w_rem, w_q[Q_W:Q_W-1]};
        assign w_trial = (SQ_RW+2)'({w_root, 2'b01});
        assign w_ge    = w_sh >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_q[s]    <= {w_q[Q_W-2:0], 2'b00};
                r_sq_rem[s]  <= w_ge ? SQ_RW'(w_sh - w_trial) : w_sh[SQ_RW-1:0];
                r_sq_root[s] <= {w_root[G_W-2:0], w_ge};
            end
        end
    end

    // gamma squared
    logic signed [127:0] w_g2;
    logic [G_W-1:0]      r_gd [MUL_LAT];

    lbf_mul #(.AW(64), .BW(64)) u_g2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   ($signed({1'b0, r_sq_root[SQRT_STAGES-1]})),
        .i_b   ($signed({1'b0, r_sq_root[SQRT_STAGES-1]})),
        .o_p   (w_g2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gd[0] <= r_sq_root[SQRT_STAGES-1];
            for (int i = 1; i < MUL_LAT; i++) begin
                r_gd[i] <= r_gd[i-1];
            end
        end
    end

    // gamma^2 / (gamma + 1); the quotient is below 2^62 so the top bits start as remainder
    logic [DEN_W-1:0] r_kd_den [KDIV_STAGES];
    logic [DEN_W-1:0] r_kd_rem [KDIV_STAGES];
    logic [K_W-1:0]   r_kd_lo  [KDIV_STAGES];
    logic [K_W-1:0]   r_kd_q   [KDIV_STAGES];
    logic [G_W-1:0]   r_kd_g   [KDIV_STAGES];

    for (genvar s = 0; s < KDIV_STAGES; s++) begin : g_kdiv
        logic [DEN_W-1:0] w_den;
        logic [DEN_W-1:0] w_rem;
        logic [K_W-1:0]   w_lo;
        logic [K_W-1:0]   w_q;
        logic [G_W-1:0]   w_g;
        logic [DEN_W:0]   w_sh;
        logic             w_ge;
        if (s == 0) begin : g_first
            assign w_g   = r_gd[MUL_LAT-1];
            assign w_den = DEN_W'({1'b0, w_g} + G_ONE);
            assign w_rem = w_g2[Q_W-1:K_W];
            assign w_lo  = w_g2[K_W-1:0];
            assign w_q   = '0;
        end else begin : g_next
            assign w_g   = r_kd_g[s-1];
            assign w_den = r_kd_den[s-1];
            assign w_rem = r_kd_rem[s-1];
            assign w_lo  = r_kd_lo[s-1];
            assign w_q   = r_kd_q[s-1];
        end
        assign w_sh = {w_rem, w_lo[K_W-1]};
        assign w_ge = w_sh >= {1'b0, w_den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_kd_g[s]   <= w_g;
                r_kd_den[s] <= w_den;
                r_kd_rem[s] <= w_ge ? DEN_W'(w_sh - {1'b0, w_den}) : w_sh[DEN_W-1:0];
                r_kd_lo[s]  <= {w_lo[K_W-2:0], 1'b0};
                r_kd_q[s]   <= {w_q[K_W-2:0], w_ge};
            end
        end
    end

    assign o_g = r_kd_g[KDIV_STAGES-1];
    assign o_k = r_kd_q[KDIV_STAGES-1];

endmodule

// ----- sv/lbf_chk.sv -----
// port-level checks for the lorentz boost top level
module lbf_chk
    import lbf_pkg::*;
#(
    parameter int MOMENTUM_WIDTH = 32
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic signed [MOMENTUM_WIDTH-1:0]  i_energy_in,
    input logic signed [MOMENTUM_WIDTH-1:0]  i_mom_x_in,
    input logic signed [MOMENTUM_WIDTH-1:0]  i_mom_y_in,
    input logic signed [MOMENTUM_WIDTH-1:0]  i_mom_z_in,
    input logic signed [BETA_W-1:0]          i_beta_x,
    input logic signed [BETA_W-1:0]          i_beta_y,
    input logic signed [BETA_W-1:0]          i_beta_z,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [MOMENTUM_WIDTH-1:0]  o_energy_out,
    input logic signed [MOMENTUM_WIDTH-1:0]  o_mom_x_out,
    input logic signed [MOMENTUM_WIDTH-1:0]  o_mom_y_out,
    input logic signed [MOMENTUM_WIDTH-1:0]  o_mom_z_out,
    input logic                              o_beta_invalid,
    input logic                              o_overflow
);

    // a held result keeps its valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped under stall");

    // a held result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_energy_out) && $stable(o_mom_x_out)
            && $stable(o_mom_y_out) && $stable(o_mom_z_out)
            && $stable(o_beta_invalid) && $stable(o_overflow))
        else $error("output changed under stall");

    // the input side only waits when a result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with a free output");

    // passthrough never reports saturation
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_beta_invalid && o_overflow))
        else $error("invalid and overflow both set");

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_energy_in) && $stable(i_mom_x_in)
            && $stable(i_mom_y_in) && $stable(i_mom_z_in) && $stable(i_beta_x)
            && $stable(i_beta_y) && $stable(i_beta_z))
        else $error("input changed under stall");

endmodule

bind lorentz_boost_four_vector_top lbf_chk #(.MOMENTUM_WIDTH(MOMENTUM_WIDTH)) u_lbf_chk (.*);
